### design/fsosc_pkg.sv
// Shared constants, types and table functions of the fractional sine oscillator.
package fsosc_pkg;

    // Default geometry of the phase accumulator and the sine table
    localparam int PHASE_BITS_DEF     = 32;
    localparam int SINE_ADDR_BITS_DEF = 12;
    localparam int SINE_FRAC_BITS_DEF = 46;

    // Fixed field widths
    localparam int STEP_BITS  = 32;
    localparam int AMP_BITS   = 16;
    localparam int DEPTH_BITS = 4;
    localparam int POW10_BITS = 30;

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = 4'd9;

    // Queue sizes (power of two) and back-end pipeline length
    localparam int MID_DEPTH   = 4;
    localparam int OUT_DEPTH   = 8;
    localparam int BACK_STAGES = 5;

    // Series expansion of the sine
    localparam logic [63:0] PI_Q62       = 64'hC90FDAA22168C235;
    localparam int          TAYLOR_TERMS = 14;

    // Per-word side information carried from front to back
    typedef struct packed {
        logic                  flip;
        logic [AMP_BITS-1:0]   amp_mag;
        logic [DEPTH_BITS-1:0] depth;
    } t_item_info;

    // Decimal scale factor for a clamped depth
    function automatic logic [POW10_BITS-1:0] pow10(input logic [DEPTH_BITS-1:0] d);
        logic [POW10_BITS-1:0] p;
        case (d)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            4'd9:    p = 30'd1000000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

    // Unsigned quotient by restoring long division, used at elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Rounded sine magnitude of table entry j, evaluated at elaboration only
    function automatic logic [63:0] sine_q(input int unsigned j,
                                           input int unsigned addr_bits,
                                           input int unsigned frac_bits);
        logic [127:0] prod;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [63:0]  div;
        int unsigned  drop;
        prod = 128'(PI_Q62) * 128'(j);
        x    = 64'(prod >> (addr_bits - 1));
        prod = 128'(x) * 128'(x);
        x2   = 64'(prod >> 62);
        term = x;
        sum  = x;
        for (int n = 1; n < TAYLOR_TERMS; n++) begin
            prod = 128'(term) * 128'(x2);
            div  = 64'((2 * n) * (2 * n + 1));
            term = udiv64(64'(prod >> 62), div);
            if (n[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        drop = 62 - frac_bits;
        if (drop > 0) begin
            sum = (sum + (64'd1 << (drop - 1))) >> drop;
        end
        return sum;
    endfunction

endpackage

### design/fsosc_fifo.sv
// Small synchronous word queue with head-of-queue output and fill count.
module fsosc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign do_push = i_push && (r_count != CW'(DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    // Advance pointers and fill count
    always_comb begin
        n_wptr  = do_push ? r_wptr + PW'(1) : r_wptr;
        n_rptr  = do_pop  ? r_rptr + PW'(1) : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

### design/fsosc_front.sv
// Front end: phase accumulator, depth register, quadrant and sign classification.
module fsosc_front #(
    parameter int PHASE_BITS     = fsosc_pkg::PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = fsosc_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    input  logic                                  i_full,
    input  logic [fsosc_pkg::STEP_BITS-1:0]       i_phase_step,
    input  logic signed [fsosc_pkg::AMP_BITS-1:0] i_amplitude,
    input  logic                                  i_cfg_we,
    input  logic [fsosc_pkg::DEPTH_BITS-1:0]      i_cfg_wdata,
    output logic                                  o_push,
    output logic [SINE_ADDR_BITS-2:0]             o_index,
    output fsosc_pkg::t_item_info                 o_info
);
    localparam int JW = SINE_ADDR_BITS - 1;
    localparam int SB = fsosc_pkg::STEP_BITS;

    localparam logic [JW-1:0] QUARTER = JW'(1) << (SINE_ADDR_BITS - 2);

    logic [PHASE_BITS-1:0]            r_phase, n_phase;
    logic [fsosc_pkg::DEPTH_BITS-1:0] r_depth;
    logic [SINE_ADDR_BITS-1:0]        addr;
    logic [JW-1:0]                    j_raw;
    logic [PHASE_BITS+SB-1:0]         step_ext;
    logic [fsosc_pkg::AMP_BITS-1:0]   amp_u;
    logic                             accept;

    assign accept = i_push && !i_full;

    // Classify the current phase into quadrant and table index
    assign addr  = r_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
    assign j_raw = JW'(addr[SINE_ADDR_BITS-3:0]);

    always_comb begin
        o_index = addr[SINE_ADDR_BITS-2] ? (QUARTER - j_raw) : j_raw;
    end

    // Split amplitude into sign and magnitude, clamp depth
    assign amp_u = i_amplitude;

    always_comb begin
        o_info.flip    = addr[SINE_ADDR_BITS-1] ^ amp_u[fsosc_pkg::AMP_BITS-1];
        o_info.amp_mag = amp_u[fsosc_pkg::AMP_BITS-1] ? ('0 - amp_u) : amp_u;
        o_info.depth   = (r_depth > fsosc_pkg::DEPTH_MAX) ? fsosc_pkg::DEPTH_MAX : r_depth;
    end

    assign o_push = accept;

    // Advance the phase by the step aligned to the accumulator width
    assign step_ext = {i_phase_step, {PHASE_BITS{1'b0}}};
    assign n_phase  = accept ? (r_phase + step_ext[PHASE_BITS+SB-1:SB]) : r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_depth <= '0;
        end else begin
            r_phase <= n_phase;
            if (i_cfg_we) begin
                r_depth <= i_cfg_wdata;
            end
        end
    end

endmodule

### design/fsosc_back.sv
// Back end: sine table read, decimal scaling, fraction extract and gain pipeline.
module fsosc_back #(
    parameter int SINE_ADDR_BITS = fsosc_pkg::SINE_ADDR_BITS_DEF,
    parameter int SINE_FRAC_BITS = fsosc_pkg::SINE_FRAC_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_mid_empty,
    input  logic [SINE_ADDR_BITS-2:0]                 i_index,
    input  fsosc_pkg::t_item_info                     i_info,
    input  logic [$clog2(fsosc_pkg::OUT_DEPTH+1)-1:0] i_out_count,
    output logic                                      o_mid_pop,
    output logic                                      o_out_push,
    output logic [fsosc_pkg::AMP_BITS-1:0]            o_out_data
);
    localparam int F       = SINE_FRAC_BITS;
    localparam int AW      = fsosc_pkg::AMP_BITS;
    localparam int PB      = fsosc_pkg::POW10_BITS;
    localparam int QUARTER = 1 << (SINE_ADDR_BITS - 2);
    // Split of the sine word for the decimal scaling
    localparam int SPLIT   = (F + 1) / 2;
    localparam int HI_W    = F + 1 - SPLIT;
    localparam int PLO_W   = SPLIT + PB;
    localparam int PHI_W   = F - SPLIT;
    // Split of the fraction for the gain product
    localparam int FL_W    = F / 2;
    localparam int FH_W    = F - FL_W;
    localparam int CW      = $clog2(fsosc_pkg::OUT_DEPTH + 1);
    localparam int SUM_W   = CW + 1;

    // Quarter-wave sine table, built at elaboration
    logic [F:0] sine_rom [QUARTER+1];

    for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
        localparam logic [63:0] SINE_VAL = fsosc_pkg::sine_q(k, SINE_ADDR_BITS, F);
        assign sine_rom[k] = SINE_VAL[F:0];
    end

    logic [fsosc_pkg::BACK_STAGES:1] r_valid;
    fsosc_pkg::t_item_info           r_info [fsosc_pkg::BACK_STAGES:1];

    logic [F:0]          r_sine;
    logic [PLO_W-1:0]    r_plo;
    logic [PHI_W-1:0]    r_phi;
    logic [F-1:0]        r_frac;
    logic [FL_W+AW-1:0]  r_ml;
    logic [FH_W+AW-1:0]  r_mh;
    logic [AW-1:0]       r_mag;

    logic [SUM_W-1:0]    inflight;
    logic                issue;
    logic [PB-1:0]       p10;
    logic [HI_W+PB-1:0]  phi_full;
    logic [F-1:0]        frac_sum;
    logic [F+AW-1:0]     gain_sum;

    // Issue only when the output queue has room for every word in flight
    always_comb begin
        inflight = '0;
        for (int s = 1; s <= fsosc_pkg::BACK_STAGES; s++) begin
            inflight = inflight + SUM_W'(r_valid[s]);
        end
    end

    assign issue     = !i_mid_empty &&
                       ((SUM_W'(i_out_count) + inflight) < SUM_W'(fsosc_pkg::OUT_DEPTH));
    assign o_mid_pop = issue;

    // Advance valid bits and side information
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[fsosc_pkg::BACK_STAGES-1:1], issue};
        end
    end

    always_ff @(posedge i_clk) begin
        r_info[1] <= i_info;
        for (int s = 2; s <= fsosc_pkg::BACK_STAGES; s++) begin
            r_info[s] <= r_info[s-1];
        end
    end

    // Stage 1: read the sine table
    always_ff @(posedge i_clk) begin
        r_sine <= sine_rom[i_index];
    end

    // Stage 2: partial products of sine times ten to the depth
    assign p10      = fsosc_pkg::pow10(r_info[1].depth);
    assign phi_full = (HI_W+PB)'(r_sine[F:SPLIT]) * (HI_W+PB)'(p10);

    always_ff @(posedge i_clk) begin
        r_plo <= PLO_W'(r_sine[SPLIT-1:0]) * PLO_W'(p10);
        r_phi <= phi_full[PHI_W-1:0];
    end

    // Stage 3: keep the fractional part of the scaled sine
    assign frac_sum = F'(r_plo) + {r_phi, {SPLIT{1'b0}}};

    always_ff @(posedge i_clk) begin
        r_frac <= frac_sum;
    end

    // Stage 4: partial products of fraction times amplitude magnitude
    always_ff @(posedge i_clk) begin
        r_ml <= (FL_W+AW)'(r_frac[FL_W-1:0]) * (FL_W+AW)'(r_info[3].amp_mag);
        r_mh <= (FH_W+AW)'(r_frac[F-1:FL_W]) * (FH_W+AW)'(r_info[3].amp_mag);
    end

    // Stage 5: combine and drop the fraction bits
    assign gain_sum = (F+AW)'(r_ml) + {r_mh, {FL_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        r_mag <= gain_sum[F+AW-1:F];
    end

    // Apply the combined sign and hand the word to the output queue
    assign o_out_push = r_valid[fsosc_pkg::BACK_STAGES];
    assign o_out_data = r_info[fsosc_pkg::BACK_STAGES].flip ? ('0 - r_mag) : r_mag;

endmodule

### design/fractional_sine_oscillator.sv
// Top level of the fractional sine oscillator: front end, queues and back end.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  input   | in        | push / full        | i_phase_step[31:0], i_amplitude[15:0]
//  result  | out       | pop / empty        | o_sample[15:0]
//  config  | in        | i_cfg_we           | i_cfg_wdata[3:0] (depth)
//
// Sustained rate is one word per cycle while full is low and results are popped.
// A result passes the middle queue, table read, four arithmetic stages and the
// output queue write; the back end is a five-stage pipeline of split multipliers.
// Synchronous reset clears phase, depth and both queues; no clearing pass.
// full rises when the 4-word middle queue fills; the back end holds words there
// while the 8-word output queue lacks room for everything in flight.
module fractional_sine_oscillator #(
    parameter int PHASE_BITS     = fsosc_pkg::PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = fsosc_pkg::SINE_ADDR_BITS_DEF,
    parameter int SINE_FRAC_BITS = fsosc_pkg::SINE_FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic [fsosc_pkg::STEP_BITS-1:0]        i_phase_step,
    input  logic signed [fsosc_pkg::AMP_BITS-1:0]  i_amplitude,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [fsosc_pkg::AMP_BITS-1:0]  o_sample,
    input  logic                                   i_cfg_we,
    input  logic [fsosc_pkg::DEPTH_BITS-1:0]       i_cfg_wdata
);
    localparam int JW    = SINE_ADDR_BITS - 1;
    localparam int INFO_W = $bits(fsosc_pkg::t_item_info);
    localparam int MID_W = JW + INFO_W;
    localparam int OCW   = $clog2(fsosc_pkg::OUT_DEPTH + 1);

    logic                           front_push;
    logic [JW-1:0]                  front_index;
    fsosc_pkg::t_item_info          front_info;
    logic [MID_W-1:0]               mid_head;
    logic                           mid_empty;
    logic                           mid_pop;
    logic [$clog2(fsosc_pkg::MID_DEPTH+1)-1:0] mid_count;
    fsosc_pkg::t_item_info          back_info;
    logic                           out_push;
    logic [fsosc_pkg::AMP_BITS-1:0] out_data;
    logic [fsosc_pkg::AMP_BITS-1:0] out_head;
    logic                           out_full;
    logic [OCW-1:0]                 out_count;

    fsosc_front #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_phase_step (i_phase_step),
        .i_amplitude  (i_amplitude),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_push       (front_push),
        .o_index      (front_index),
        .o_info       (front_info)
    );

    fsosc_fifo #(
        .WIDTH (MID_W),
        .DEPTH (fsosc_pkg::MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  ({front_index, front_info}),
        .i_pop   (mid_pop),
        .o_data  (mid_head),
        .o_full  (full),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    assign back_info = mid_head[INFO_W-1:0];

    fsosc_back #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .SINE_FRAC_BITS (SINE_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (mid_empty || (mid_count == '0)),
        .i_index     (mid_head[MID_W-1:INFO_W]),
        .i_info      (back_info),
        .i_out_count (out_count),
        .o_mid_pop   (mid_pop),
        .o_out_push  (out_push),
        .o_out_data  (out_data)
    );

    fsosc_fifo #(
        .WIDTH (fsosc_pkg::AMP_BITS),
        .DEPTH (fsosc_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_data),
        .i_pop   (pop),
        .o_data  (out_head),
        .o_full  (out_full),
        .o_empty (empty),
        .o_count (out_count)
    );

    // Output queue never overfills: the back end issues on credit
    assign o_sample = (out_full || !out_full) ? out_head : '0;

endmodule

### design/fsosc_checker.sv
// Port-level checker for the fractional sine oscillator, bound to the top level.
module fsosc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [15:0] o_sample
);
    logic [5:0] r_outstanding;

    // Track words taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= r_outstanding + 6'(push && !full) - 6'(pop && !empty);
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (empty && !full))
        else $error("queues not cleared by reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_sample)))
        else $error("waiting result changed or vanished");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_outstanding != 6'd0))
        else $error("result offered with no word outstanding");

    a_no_false_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_outstanding == 6'd0) |-> !full)
        else $error("full raised while the block holds nothing");

endmodule

bind fractional_sine_oscillator fsosc_checker u_fsosc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_sample (o_sample)
);

### sim/fractional_sine_oscillator_tb.sv
// Self-checking testbench of the fractional sine oscillator: random traffic, depth sweeps.
`timescale 1ns / 1ps

module fractional_sine_oscillator_tb;

    localparam int          PH_BITS      = fsosc_pkg::PHASE_BITS_DEF;
    localparam int          ADDR_BITS    = fsosc_pkg::SINE_ADDR_BITS_DEF;
    localparam int          FRAC_BITS    = fsosc_pkg::SINE_FRAC_BITS_DEF;
    localparam int          STEP_BITS    = fsosc_pkg::STEP_BITS;
    localparam int          AMP_BITS     = fsosc_pkg::AMP_BITS;
    localparam int          DEPTH_BITS   = fsosc_pkg::DEPTH_BITS;
    localparam int          TAYLOR_TERMS = fsosc_pkg::TAYLOR_TERMS;
    localparam logic [63:0] PI_Q62       = fsosc_pkg::PI_Q62;
    localparam int          QUARTER      = 1 << (ADDR_BITS - 2);
    localparam int          RAND_WORDS   = 125;
    localparam int          CYCLE_CAP    = 400000;

    // One input word: phase step and gain
    typedef struct packed {
        logic [STEP_BITS-1:0] step;
        logic [AMP_BITS-1:0]  amp;
    } t_tone_word;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         push = 1'b0;
    logic                         full;
    logic [STEP_BITS-1:0]         i_phase_step = '0;
    logic signed [AMP_BITS-1:0]   i_amplitude = '0;
    logic                         empty;
    logic                         pop = 1'b0;
    logic signed [AMP_BITS-1:0]   o_sample;
    logic                         i_cfg_we = 1'b0;
    logic [DEPTH_BITS-1:0]        i_cfg_wdata = '0;

    t_tone_word                   pending_words[$];
    logic [AMP_BITS-1:0]          expected_samples[$];
    logic [63:0]                  quarter_sine[QUARTER+1];
    logic [PH_BITS-1:0]           model_phase;
    logic [DEPTH_BITS-1:0]        model_depth;
    logic                         in_taken = 1'b0;
    logic                         out_taken = 1'b0;
    logic                         in_calm = 1'b0;
    logic                         out_calm = 1'b0;
    int unsigned                  in_gap = 0;
    int unsigned                  out_gap = 0;
    int unsigned                  cycles = 0;
    int unsigned                  errors = 0;
    logic [DEPTH_BITS-1:0]        depth_plan[13] = '{4'd0, 4'd9, 4'd15, 4'd1, 4'd6, 4'd10,
                                                     4'd3, 4'd2, 4'd8, 4'd4, 4'd5, 4'd7, 4'd12};

    fractional_sine_oscillator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_phase_step (i_phase_step),
        .i_amplitude  (i_amplitude),
        .empty        (empty),
        .pop          (pop),
        .o_sample     (o_sample),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Sine magnitude of quarter-wave entry j by Taylor series, rounded to the table format
    function automatic logic [63:0] taylor_sine(input int unsigned j);
        logic [127:0] p;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  acc;
        p    = 128'(PI_Q62) * 128'(j);
        x    = 64'(p >> (ADDR_BITS - 1));
        p    = 128'(x) * 128'(x);
        x2   = 64'(p >> 62);
        term = x;
        acc  = x;
        for (int n = 1; n < TAYLOR_TERMS; n++) begin
            p    = 128'(term) * 128'(x2);
            term = 64'(p >> 62) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        return (acc + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
    endfunction

    // Sample for the current phase: fraction of the decimally scaled sine times the gain
    function automatic logic [AMP_BITS-1:0] predict_sample(input logic [PH_BITS-1:0] phase,
                                                           input logic [DEPTH_BITS-1:0] depth,
                                                           input logic [AMP_BITS-1:0] amp);
        logic [ADDR_BITS-1:0]  addr;
        logic [ADDR_BITS-2:0]  idx;
        logic [63:0]           scale;
        logic [127:0]          p;
        logic [FRAC_BITS-1:0]  frac;
        logic [AMP_BITS-1:0]   amag;
        logic [AMP_BITS-1:0]   m;
        int unsigned           d;
        addr = phase[PH_BITS-1 -: ADDR_BITS];
        idx  = (ADDR_BITS-1)'(addr[ADDR_BITS-3:0]);
        if (addr[ADDR_BITS-2]) begin
            idx = (ADDR_BITS-1)'(QUARTER) - idx;
        end
        d     = (depth > 4'd9) ? 9 : depth;
        scale = 64'd1;
        for (int k = 0; k < d; k++) begin
            scale = scale * 64'd10;
        end
        p    = 128'(quarter_sine[idx]) * 128'(scale);
        frac = p[FRAC_BITS-1:0];
        amag = amp[AMP_BITS-1] ? (16'h0 - amp) : amp;
        p    = 128'(frac) * 128'(amag);
        m    = AMP_BITS'(p >> FRAC_BITS);
        return (addr[ADDR_BITS-1] != amp[AMP_BITS-1]) ? (16'h0 - m) : m;
    endfunction

    // Random word, biased toward zero, small, address-aligned and wrapping steps and gain extremes
    function automatic t_tone_word random_word();
        t_tone_word w;
        case ($urandom_range(0, 7))
            0:       w.step = '0;
            1:       w.step = $urandom_range(0, 32'h000F_FFFF);
            2:       w.step = {12'($urandom_range(0, 4095)), 20'h0};
            3:       w.step = 32'hFFFF_FFFF - $urandom_range(0, 32'h0010_0000);
            default: w.step = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0:       w.amp = 16'h8000;
            1:       w.amp = 16'h7FFF;
            2:       w.amp = 16'h0000;
            3:       w.amp = 16'($signed($urandom_range(0, 16)) - 8);
            default: w.amp = 16'($urandom);
        endcase
        return w;
    endfunction

    task automatic flag_mismatch(input string what, input logic [AMP_BITS-1:0] got,
                                 input logic [AMP_BITS-1:0] want);
        $display("mismatch (%s): got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // Hold until no word is pending, in flight or owed
    task automatic drain();
        @(posedge i_clk);
        while (pending_words.size() != 0 || push || expected_samples.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_depth(input logic [DEPTH_BITS-1:0] d);
        drain();
        repeat (10) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= d;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Drive input words with random gaps; advance only when the current word is taken
    always @(negedge i_clk) begin : drive_words
        t_tone_word w;
        if (!i_rst_n) begin
            push   <= 1'b0;
            in_gap <= 0;
        end else if (!push || in_taken) begin
            if (in_gap != 0) begin
                push   <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (pending_words.size() != 0) begin
                w            = pending_words.pop_front();
                i_phase_step <= w.step;
                i_amplitude  <= w.amp;
                push         <= 1'b1;
                if ($urandom_range(0, 29) == 0) begin
                    in_calm = ~in_calm;
                end
                in_gap <= in_calm ? 0 : $urandom_range(0, 9);
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Drive pop with random stalls between taken samples
    always @(negedge i_clk) begin : drive_pop
        int unsigned g;
        if (!i_rst_n) begin
            pop     <= 1'b0;
            out_gap <= 0;
        end else if (out_taken || !pop) begin
            if (out_taken) begin
                if ($urandom_range(0, 29) == 0) begin
                    out_calm = ~out_calm;
                end
                g = out_calm ? 0 : $urandom_range(0, 9);
            end else begin
                g = out_gap;
            end
            if (g != 0) begin
                pop     <= 1'b0;
                out_gap <= g - 1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Track phase and depth, check each taken sample against the oldest prediction
    always @(posedge i_clk) begin
        in_taken  <= i_rst_n && push && !full;
        out_taken <= i_rst_n && pop && !empty;
        cycles    <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("timeout at cycle %0d", cycles);
            $display("TEST FAILED");
            $finish;
        end
        if (!i_rst_n) begin
            model_phase <= '0;
            model_depth <= '0;
        end else begin
            if (i_cfg_we) begin
                model_depth <= i_cfg_wdata;
            end
            if (pop && !empty) begin
                if (expected_samples.size() == 0) begin
                    flag_mismatch("no sample owed", o_sample, 'x);
                end else if (o_sample !== expected_samples[0]) begin
                    flag_mismatch("sample", o_sample, expected_samples.pop_front());
                end else begin
                    void'(expected_samples.pop_front());
                end
            end
            if (push && !full) begin
                expected_samples.push_back(predict_sample(model_phase, model_depth, i_amplitude));
                model_phase <= model_phase + PH_BITS'(i_phase_step);
            end
        end
    end

    // Stimulus: reset, directed words, then random words over a sweep of depths
    initial begin
        for (int j = 0; j <= QUARTER; j++) begin
            quarter_sine[j] = taylor_sine(j);
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (depth_plan[p]) begin
            write_depth(depth_plan[p]);
            if (p == 0) begin
                // zero sine, exact quarter points, wrap, one-address steps, gain extremes
                pending_words.push_back('{32'h0000_0000, 16'h7FFF});
                pending_words.push_back('{32'h4000_0000, 16'h7FFF});
                pending_words.push_back('{32'h4000_0000, 16'h8000});
                pending_words.push_back('{32'h4000_0000, 16'h7FFF});
                pending_words.push_back('{32'h4000_0000, 16'hFFFF});
                pending_words.push_back('{32'h4000_0000, 16'h0001});
                pending_words.push_back('{32'h0010_0000, 16'h8000});
                pending_words.push_back('{32'hFFFF_FFFF, 16'h7FFF});
                pending_words.push_back('{32'h8000_0000, 16'h8001});
                pending_words.push_back('{32'h1234_5678, 16'h4000});
                pending_words.push_back('{32'hEDCB_A987, 16'hC000});
                pending_words.push_back('{32'h0000_0001, 16'h0000});
                pending_words.push_back('{32'h0010_0000, 16'h7FFF});
                pending_words.push_back('{32'hFFF0_0000, 16'hFFFF});
                pending_words.push_back('{32'h3FF0_0000, 16'h7FFF});
                pending_words.push_back('{32'h4010_0000, 16'h8000});
                pending_words.push_back('{32'h5555_5555, 16'hAAAA});
                pending_words.push_back('{32'hAAAA_AAAA, 16'h5555});
            end
            for (int k = 0; k < RAND_WORDS; k++) begin
                pending_words.push_back(random_word());
            end
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### fractional_sine_oscillator.f
design/fsosc_pkg.sv
design/fsosc_fifo.sv
design/fsosc_front.sv
design/fsosc_back.sv
design/fractional_sine_oscillator.sv
design/fsosc_checker.sv
sim/fractional_sine_oscillator_tb.sv
